// File: rtl/core/swrsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swrsc_pkg
// shared types, mode codes and small arithmetic helpers of the stopwatch
// ----------------------------------------------------------------------------
package swrsc_pkg;

	localparam logic [1:0] MODE_STOP  = 2'd0;
	localparam logic [1:0] MODE_RUN   = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam int unsigned BIT_STOPPED = 5;
	localparam int unsigned BIT_RUNNING = 7;

	localparam logic [7:0] CMD_RUN   = 8'h72;
	localparam logic [7:0] CMD_CLEAR = 8'h63;

	localparam logic [6:0] CENTI_LAST  = 7'd99;
	localparam logic [5:0] SECOND_LAST = 6'd59;
	localparam logic [5:0] MINUTE_LAST = 6'd59;
	localparam logic [4:0] HOUR_LAST   = 5'd23;

	localparam logic [9:0] ROT_TIMER_MAX = 10'd1023;
	localparam logic [7:0] PATTERN_INIT  = 8'h01;

	localparam logic [7:0] STEP_RESET   = 8'd10;
	localparam logic [9:0] PERIOD_RESET = 10'd100;

	localparam logic [2:0] ADDR_STEP   = 3'd0;
	localparam logic [2:0] ADDR_PERIOD = 3'd4;

	typedef struct packed {
		logic [7:0] time_step_ms;
		logic [9:0] rotate_period_ms;
	} swrsc_cfg_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic [6:0] centis;
		logic [7:0] pattern;
		logic [7:0] status;
	} swrsc_state_t;

	typedef struct packed {
		logic [13:0] value;
		logic        dot_fast;
		logic        dot_slow;
	} swrsc_disp_t;

	// quotient by ten of a 7 bit value, exact below 179
	function automatic logic [3:0] div10(input logic [6:0] x);
		logic [16:0] prod;
		prod = {10'd0, x} * 17'd103;
		return prod[13:10];
	endfunction

	function automatic logic [3:0] mod10(input logic [6:0] x);
		logic [3:0] q;
		logic [6:0] q10;
		q   = div10(x);
		q10 = {q, 3'd0} + {2'd0, q, 1'd0};
		return 4'(x - q10);
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/swrsc_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swrsc_cfg
// apb register file holding the step and rotate periods
// ----------------------------------------------------------------------------
module swrsc_cfg
	import swrsc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output swrsc_cfg_t       cfg
);

	logic [7:0] step_q;
	logic [9:0] period_q;
	logic       wr_en;
	logic       sel_period;

	assign pready     = 1'b1;
	assign wr_en      = psel & penable & pwrite;
	assign sel_period = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_RESET;
			period_q <= PERIOD_RESET;
		end else if (wr_en) begin
			if (sel_period) begin
				period_q <= pwdata[9:0];
			end else begin
				step_q <= pwdata[7:0];
			end
		end
	end

	always_comb begin
		if (sel_period) begin
			prdata = {22'd0, period_q};
		end else begin
			prdata = {24'd0, step_q};
		end
	end

	assign cfg.time_step_ms     = step_q;
	assign cfg.rotate_period_ms = period_q;

endmodule
`default_nettype wire

// File: rtl/core/swrsc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swrsc_core
// mode, time count, dividers and led state, updated once per request
// ----------------------------------------------------------------------------
module swrsc_core
	import swrsc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         accept,
	input  wire swrsc_cfg_t   cfg,
	input  wire logic         ms_tick,
	input  wire logic         run_stop_press,
	input  wire logic         clear_press,
	input  wire logic         rx_valid,
	input  wire logic [7:0]   rx_byte,
	output swrsc_state_t      state_n,
	output logic              state_mode_bad
);

	swrsc_state_t state_q;
	logic [7:0]   div_q;
	logic [9:0]   rot_q;
	logic [7:0]   pend_q;

	logic [7:0]   pend_t;
	logic [7:0]   div_inc;
	logic [7:0]   div_n;
	logic [9:0]   rot_t;
	logic [9:0]   rot_n;
	logic [7:0]   pend_n;
	logic         step;
	swrsc_state_t t;

	assign state_mode_bad = (state_q.mode == 2'd3);

	always_comb begin
		pend_t  = rx_valid ? rx_byte : pend_q;
		div_inc = div_q + 8'd1;
		step    = ms_tick && ((div_inc >= cfg.time_step_ms) || (div_inc == 8'd0));
		div_n   = ms_tick ? (step ? 8'd0 : div_inc) : div_q;
		rot_t   = (ms_tick && (rot_q < ROT_TIMER_MAX)) ? rot_q + 10'd1 : rot_q;

		// time advance
		t = state_q;
		if (step && (state_q.mode == MODE_RUN)) begin
			if (t.centis < CENTI_LAST) begin
				t.centis = t.centis + 7'd1;
			end else begin
				t.centis = '0;
				if (t.seconds < SECOND_LAST) begin
					t.seconds = t.seconds + 6'd1;
				end else begin
					t.seconds = '0;
					if (t.minutes < MINUTE_LAST) begin
						t.minutes = t.minutes + 6'd1;
					end else begin
						t.minutes = '0;
						if (t.hours < HOUR_LAST) begin
							t.hours = t.hours + 5'd1;
						end else begin
							t.hours = '0;
						end
					end
				end
			end
		end

		// mode update
		pend_n = pend_t;
		unique case (state_q.mode)
			MODE_STOP: begin
				priority if (run_stop_press) begin
					t.mode = MODE_RUN;
				end else if (clear_press) begin
					t.mode = MODE_CLEAR;
				end else if (pend_t == CMD_RUN) begin
					pend_n = '0;
					t.mode = MODE_RUN;
				end else if (pend_t == CMD_CLEAR) begin
					pend_n = '0;
					t.mode = MODE_CLEAR;
				end else begin
					t.mode = MODE_STOP;
				end
			end
			MODE_RUN: begin
				priority if (run_stop_press) begin
					t.mode = MODE_STOP;
				end else if (pend_t == CMD_RUN) begin
					pend_n = '0;
					t.mode = MODE_STOP;
				end else begin
					t.mode = MODE_RUN;
				end
			end
			MODE_CLEAR: begin
				t.mode    = MODE_STOP;
				t.hours   = '0;
				t.minutes = '0;
				t.seconds = '0;
				t.centis  = '0;
			end
			default: begin
				t.mode = MODE_STOP;
			end
		endcase

		// leds
		rot_n = rot_t;
		unique case (t.mode)
			MODE_STOP: begin
				t.status[BIT_STOPPED] = 1'b1;
				t.status[BIT_RUNNING] = 1'b0;
			end
			MODE_RUN: begin
				t.status[BIT_STOPPED] = 1'b0;
				t.status[BIT_RUNNING] = 1'b1;
				if (rot_t >= cfg.rotate_period_ms) begin
					rot_n     = '0;
					t.pattern = {t.pattern[6:0], t.pattern[7]};
				end
			end
			MODE_CLEAR: begin
				t.pattern = PATTERN_INIT;
			end
			default: begin
			end
		endcase

		state_n = t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode    <= MODE_STOP;
			state_q.hours   <= '0;
			state_q.minutes <= '0;
			state_q.seconds <= '0;
			state_q.centis  <= '0;
			state_q.pattern <= PATTERN_INIT;
			state_q.status  <= '0;
			div_q           <= '0;
			rot_q           <= '0;
			pend_q          <= '0;
		end else if (accept) begin
			state_q <= state_n;
			div_q   <= div_n;
			rot_q   <= rot_n;
			pend_q  <= pend_n;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/swrsc_fmt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swrsc_fmt
// composes the four digit display number and the blinking points
// ----------------------------------------------------------------------------
module swrsc_fmt
	import swrsc_pkg::*;
(
	input  wire swrsc_state_t state,
	output swrsc_disp_t       disp
);

	logic [3:0]  min_digit;
	logic [3:0]  centi_tens;
	logic [3:0]  tenth_digit;
	logic [3:0]  centi_ones;
	logic [13:0] min_part;
	logic [13:0] sec_part;

	always_comb begin
		min_digit   = mod10({1'b0, state.minutes});
		centi_tens  = div10(state.centis);
		tenth_digit = (centi_tens >= 4'd10) ? centi_tens - 4'd10 : centi_tens;
		centi_ones  = mod10(state.centis);
		min_part    = {10'd0, min_digit} * 14'd1000;
		sec_part    = {5'd0, state.seconds, 3'd0} + {7'd0, state.seconds, 1'd0};
		disp.value    = min_part + sec_part + {10'd0, tenth_digit};
		disp.dot_fast = (centi_ones < 4'd5);
		disp.dot_slow = (state.centis < 7'd50);
	end

endmodule
`default_nettype wire

// File: rtl/core/stopwatch_run_stop_clear.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stopwatch_run_stop_clear
// hh:mm:ss.cc stopwatch with run, stop and clear control
// ----------------------------------------------------------------------------
// Each input request is one polling pass: millisecond tick, run/stop and
// clear presses and an optional received byte ('r' toggles run, 'c' clears).
// Each request gives exactly one result: mode, time, display number, the two
// blinking points and the led patterns after that pass.
// The result is registered at the accepting edge and shows on out_valid in
// the next cycle. One request is taken every cycle unless a result stalls;
// the mode and time registers close their loop combinationally.
// in_ready is low only while a result waits and out_ready is low, so a
// stalled receiver holds the result and the state stays frozen.
// The apb port sets the step period (address 0) and the led rotate period
// (address 4); write it only while the block is idle.
// Reset puts the watch in stop at 00:00:00.00, pattern 0x01, status 0,
// step 10 ms and rotate period 100 ms.
// ----------------------------------------------------------------------------
module stopwatch_run_stop_clear
	import swrsc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        ms_tick,
	input  wire logic        run_stop_press,
	input  wire logic        clear_press,
	input  wire logic        rx_valid,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [1:0]  watch_mode,
	output logic      [4:0]  hours,
	output logic      [5:0]  minutes,
	output logic      [5:0]  seconds,
	output logic      [6:0]  centis,
	output logic      [13:0] display_value,
	output logic             dot_fast,
	output logic             dot_slow,
	output logic      [7:0]  led_pattern,
	output logic      [7:0]  status_leds
);

	swrsc_cfg_t   cfg;
	swrsc_state_t state_n;
	swrsc_disp_t  disp_n;
	swrsc_state_t res_state_q;
	swrsc_disp_t  res_disp_q;
	logic         out_valid_q;
	logic         accept;
	logic         mode_bad;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	swrsc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	swrsc_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.cfg            (cfg),
		.ms_tick        (ms_tick),
		.run_stop_press (run_stop_press),
		.clear_press    (clear_press),
		.rx_valid       (rx_valid),
		.rx_byte        (rx_byte),
		.state_n        (state_n),
		.state_mode_bad (mode_bad)
	);

	swrsc_fmt u_fmt (
		.state (state_n),
		.disp  (disp_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_state_q <= state_n;
			res_disp_q  <= disp_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign watch_mode    = res_state_q.mode;
	assign hours         = res_state_q.hours;
	assign minutes       = res_state_q.minutes;
	assign seconds       = res_state_q.seconds;
	assign centis        = res_state_q.centis;
	assign display_value = res_disp_q.value;
	assign dot_fast      = res_disp_q.dot_fast;
	assign dot_slow      = res_disp_q.dot_slow;
	assign led_pattern   = res_state_q.pattern;
	assign status_leds   = res_state_q.status;

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted request gave no result");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("request taken while result stalled");

	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		!mode_bad)
		else $error("unused mode code in state");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (centis <= CENTI_LAST && seconds <= SECOND_LAST &&
			minutes <= MINUTE_LAST && hours <= HOUR_LAST))
		else $error("time count out of range");

endmodule
`default_nettype wire

// File: tb/stopwatch_run_stop_clear_tb.sv
// ----------------------------------------------------------------------------
// stopwatch_run_stop_clear_tb
// self-checking bench for the run / stop / clear stopwatch
// ----------------------------------------------------------------------------
// Polling passes go in on a valid/ready channel in bursts with random gaps,
// and results are drained by a receiver that stalls in changing patterns.
// A scoreboard keeps its own copy of the watch state and registers, predicts
// each result from the accepted request and checks every field. The run walks
// through directed mode and command cases, random passes under several step
// and rotate periods including the extremes, and a run across second carries.
// ----------------------------------------------------------------------------
module stopwatch_run_stop_clear_tb;
	import swrsc_pkg::*;

	localparam int IDLE_LIMIT = 5000;

	typedef struct packed {
		logic       tick;
		logic       run_stop;
		logic       clear;
		logic       rx_valid;
		logic [7:0] rx_byte;
	} pass_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic [6:0]  centis;
		logic [13:0] display;
		logic        dot_fast;
		logic        dot_slow;
		logic [7:0]  pattern;
		logic [7:0]  status;
	} watch_t;

	class stopwatch_scoreboard;
		logic [7:0] step_ms;
		logic [9:0] rot_period;
		logic [1:0] mode;
		logic [4:0] hh;
		logic [5:0] mm;
		logic [5:0] ss;
		logic [6:0] cc;
		logic [7:0] step_div;
		logic [9:0] rot_tmr;
		logic [7:0] pattern;
		logic [7:0] status;
		logic [7:0] held_byte;
		watch_t     due_q[$];
		int         errors;

		function new();
			step_ms    = STEP_RESET;
			rot_period = PERIOD_RESET;
			mode       = MODE_STOP;
			hh         = '0;
			mm         = '0;
			ss         = '0;
			cc         = '0;
			step_div   = '0;
			rot_tmr    = '0;
			pattern    = PATTERN_INIT;
			status     = '0;
			held_byte  = '0;
			errors     = 0;
		endfunction

		function void set_register(logic [2:0] addr, logic [31:0] data);
			case (addr)
				ADDR_STEP:   step_ms = data[7:0];
				ADDR_PERIOD: rot_period = data[9:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		function void note_request(pass_t p);
			watch_t      w;
			int unsigned disp;
			if (p.rx_valid)
				held_byte = p.rx_byte;
			if (p.tick) begin
				step_div = step_div + 8'd1;
				if (step_div >= step_ms || step_div == 8'd0) begin
					step_div = '0;
					if (mode == MODE_RUN) begin
						if (cc < CENTI_LAST) cc = cc + 7'd1;
						else begin
							cc = '0;
							if (ss < SECOND_LAST) ss = ss + 6'd1;
							else begin
								ss = '0;
								if (mm < MINUTE_LAST) mm = mm + 6'd1;
								else begin
									mm = '0;
									if (hh < HOUR_LAST) hh = hh + 5'd1;
									else hh = '0;
								end
							end
						end
					end
				end
				if (rot_tmr != ROT_TIMER_MAX)
					rot_tmr = rot_tmr + 10'd1;
			end
			case (mode)
				MODE_STOP: begin
					if (p.run_stop) mode = MODE_RUN;
					else if (p.clear) mode = MODE_CLEAR;
					else if (held_byte == CMD_RUN) begin
						held_byte = '0;
						mode = MODE_RUN;
					end else if (held_byte == CMD_CLEAR) begin
						held_byte = '0;
						mode = MODE_CLEAR;
					end
				end
				MODE_RUN: begin
					if (p.run_stop) mode = MODE_STOP;
					else if (held_byte == CMD_RUN) begin
						held_byte = '0;
						mode = MODE_STOP;
					end
				end
				MODE_CLEAR: begin
					mode = MODE_STOP;
					hh = '0;
					mm = '0;
					ss = '0;
					cc = '0;
				end
				default: mode = MODE_STOP;
			endcase
			case (mode)
				MODE_STOP: begin
					status[BIT_STOPPED] = 1'b1;
					status[BIT_RUNNING] = 1'b0;
				end
				MODE_RUN: begin
					status[BIT_STOPPED] = 1'b0;
					status[BIT_RUNNING] = 1'b1;
					if (rot_tmr >= rot_period) begin
						rot_tmr = '0;
						pattern = {pattern[6:0], pattern[7]};
					end
				end
				MODE_CLEAR: pattern = PATTERN_INIT;
				default: ;
			endcase
			disp = (int'(mm) % 10) * 1000 + int'(ss) * 10 + (int'(cc) / 10) % 10;
			w.mode     = mode;
			w.hours    = hh;
			w.minutes  = mm;
			w.seconds  = ss;
			w.centis   = cc;
			w.display  = disp[13:0];
			w.dot_fast = (int'(cc) % 10) < 5;
			w.dot_slow = cc < 7'd50;
			w.pattern  = pattern;
			w.status   = status;
			due_q.push_back(w);
		endfunction

		function void cmp(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(watch_t got);
			watch_t want;
			if (due_q.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			want = due_q.pop_front();
			cmp("watch_mode", want.mode, got.mode);
			cmp("hours", want.hours, got.hours);
			cmp("minutes", want.minutes, got.minutes);
			cmp("seconds", want.seconds, got.seconds);
			cmp("centis", want.centis, got.centis);
			cmp("display_value", want.display, got.display);
			cmp("dot_fast", want.dot_fast, got.dot_fast);
			cmp("dot_slow", want.dot_slow, got.dot_slow);
			cmp("led_pattern", want.pattern, got.pattern);
			cmp("status_leds", want.status, got.status);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        ms_tick = 1'b0;
	logic        run_stop_press = 1'b0;
	logic        clear_press = 1'b0;
	logic        rx_valid = 1'b0;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  watch_mode;
	logic [4:0]  hours;
	logic [5:0]  minutes;
	logic [5:0]  seconds;
	logic [6:0]  centis;
	logic [13:0] display_value;
	logic        dot_fast;
	logic        dot_slow;
	logic [7:0]  led_pattern;
	logic [7:0]  status_leds;

	stopwatch_scoreboard sb;
	pass_t               pass_q[$];
	pass_t               cur_pass;
	int                  burst_left = 1;
	int                  gap_left = 0;
	bit                  draining = 1'b0;
	int                  stall_kind = 0;
	int                  stall_left = 0;
	int                  idle_cycles = 0;
	watch_t              seen;

	stopwatch_run_stop_clear dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	// request side: bursts, gaps and the odd wait for a full drain
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_request(cur_pass);
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (draining) begin
					in_valid <= 1'b0;
					if (sb.pending() == 0)
						draining = 1'b0;
				end else if (pass_q.size() != 0) begin
					cur_pass = pass_q.pop_front();
					in_valid <= 1'b1;
					ms_tick <= cur_pass.tick;
					run_stop_press <= cur_pass.run_stop;
					clear_press <= cur_pass.clear;
					rx_valid <= cur_pass.rx_valid;
					rx_byte <= cur_pass.rx_byte;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
						if ($urandom_range(0, 29) == 0)
							draining = 1'b1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen = {watch_mode, hours, minutes, seconds, centis, display_value,
					dot_fast, dot_slow, led_pattern, status_leds};
				sb.check_result(seen);
			end
			if (stall_left == 0) begin
				stall_kind = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 200);
			end else begin
				stall_left--;
			end
			case (stall_kind)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= (stall_left % 4) == 0;
				default: out_ready <= $urandom_range(0, 15) == 0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("stopwatch_run_stop_clear_tb failed");
				$finish;
			end
		end
	end

	function automatic pass_t mk(logic t, logic rs, logic cl, logic rv, logic [7:0] b);
		pass_t p;
		p.tick     = t;
		p.run_stop = rs;
		p.clear    = cl;
		p.rx_valid = rv;
		p.rx_byte  = b;
		return p;
	endfunction

	task automatic apb_access(input logic wr, input logic [2:0] addr,
		input logic [31:0] data, output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_periods(input logic [7:0] step, input logic [9:0] period);
		logic [31:0] rd;
		apb_access(1'b1, ADDR_STEP, {24'd0, step}, rd);
		sb.set_register(ADDR_STEP, {24'd0, step});
		apb_access(1'b1, ADDR_PERIOD, {22'd0, period}, rd);
		sb.set_register(ADDR_PERIOD, {22'd0, period});
		apb_access(1'b0, ADDR_STEP, '0, rd);
		sb.cmp("time_step_ms", step, rd);
		apb_access(1'b0, ADDR_PERIOD, '0, rd);
		sb.cmp("rotate_period_ms", period, rd);
	endtask

	task automatic add_random(input int n);
		pass_t p;
		for (int i = 0; i < n; i++) begin
			p.tick     = $urandom_range(0, 9) < 8;
			p.run_stop = $urandom_range(0, 24) == 0;
			p.clear    = $urandom_range(0, 19) == 0;
			p.rx_valid = $urandom_range(0, 11) == 0;
			case ($urandom_range(0, 3))
				0: p.rx_byte = CMD_RUN;
				1: p.rx_byte = CMD_CLEAR;
				default: p.rx_byte = 8'($urandom);
			endcase
			pass_q.push_back(p);
		end
	endtask

	task automatic settle();
		do @(negedge clk); while (pass_q.size() != 0 || in_valid || sb.pending() != 0);
		repeat (2) @(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// mode changes, held commands and byte overwrite at reset periods
		pass_q.push_back(mk(0, 0, 0, 0, 8'h00));
		pass_q.push_back(mk(0, 0, 0, 1, CMD_RUN));
		pass_q.push_back(mk(1, 0, 1, 0, 8'h00));
		pass_q.push_back(mk(1, 0, 0, 1, CMD_CLEAR));
		pass_q.push_back(mk(1, 1, 0, 0, 8'h00));
		pass_q.push_back(mk(0, 0, 0, 0, 8'h00));
		pass_q.push_back(mk(1, 0, 0, 0, 8'h00));
		pass_q.push_back(mk(0, 1, 1, 0, 8'h00));
		pass_q.push_back(mk(0, 1, 0, 1, CMD_RUN));
		pass_q.push_back(mk(0, 0, 0, 0, 8'h00));
		pass_q.push_back(mk(1, 0, 0, 1, 8'hFF));
		pass_q.push_back(mk(1, 1, 0, 0, 8'h00));
		pass_q.push_back(mk(1, 0, 0, 0, 8'h00));
		pass_q.push_back(mk(1, 0, 1, 1, 8'h00));
		pass_q.push_back(mk(1, 0, 0, 1, CMD_RUN));
		pass_q.push_back(mk(1, 0, 0, 0, 8'h00));
		pass_q.push_back(mk(0, 1, 0, 1, CMD_RUN));
		pass_q.push_back(mk(0, 0, 0, 1, 8'h41));
		pass_q.push_back(mk(1, 0, 0, 0, 8'h00));
		pass_q.push_back(mk(1, 0, 0, 1, 8'h8D));
		pass_q.push_back(mk(1, 0, 0, 1, CMD_RUN));
		for (int i = 0; i < 3; i++)
			pass_q.push_back(mk(1, 0, 0, 0, 8'h00));
		settle();

		set_periods(8'd1, 10'd1);
		add_random(350);
		settle();
		set_periods(8'd255, 10'd1000);
		add_random(400);
		settle();
		set_periods(8'd0, 10'd0);
		add_random(250);
		settle();
		set_periods(8'($urandom_range(2, 20)), 10'($urandom_range(1, 1023)));
		add_random(350);
		settle();

		// clear, then run flat out across second carries
		set_periods(8'd1, 10'd1023);
		pass_q.push_back(mk(0, sb.mode == MODE_RUN, 0, 1, 8'h00));
		pass_q.push_back(mk(0, 0, 1, 0, 8'h00));
		pass_q.push_back(mk(0, 0, 0, 0, 8'h00));
		pass_q.push_back(mk(1, 1, 0, 0, 8'h00));
		for (int i = 0; i < 250; i++)
			pass_q.push_back(mk(1, 0, 0, 0, 8'h00));
		settle();

		repeat (4) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d results never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("stopwatch_run_stop_clear_tb passed");
		else
			$display("stopwatch_run_stop_clear_tb failed");
		$finish;
	end

endmodule
